[src/assert_macros.svh]
// Assertion macros shared by the beat detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define AEBD_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("aebd assertion failed");
// Checked at every edge, reset included.
`define AEBD_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("aebd assertion failed");
`else
`define AEBD_ASSERT(name, clk, rstn, prop)
`define AEBD_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

[src/aebd_pkg.sv]
// Shared types, constants and the leaky average update of the beat detector.
package aebd_pkg;

    localparam int AVG_W     = 18;  // Q10.8 averages
    localparam int Q_BITS    = 8;
    localparam int LVL_W     = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int R_MAX_W   = 16;  // widest rectified sample

    localparam logic [7:0] DECAY_Q8 = 8'd230;
    localparam logic [7:0] GAIN_Q8  = 8'd26;

    localparam logic [AVG_W-1:0] AVG_MAX = '1;

    localparam logic [CFG_W-1:0] CENTRE_RST = 10'd512;
    localparam logic [CFG_W-1:0] MIN_RST    = 10'd100;
    localparam logic [CFG_W-1:0] RATIO_RST  = 10'd307;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTRE = 2'd0,
        CFG_MIN    = 2'd1,
        CFG_RATIO  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic first;
        logic last;
    } t_tag;

    // avg' = floor(avg * 0.9) + r * 0.1, saturated to the average width
    function automatic logic [AVG_W-1:0] leak(input logic [AVG_W-1:0] avg,
                                              input logic [R_MAX_W-1:0] r);
        logic [AVG_W+7:0]   dec;
        logic [R_MAX_W+7:0] inc;
        logic [R_MAX_W+8:0] sum;
        dec = avg * DECAY_Q8;
        inc = r * GAIN_Q8;
        sum = (R_MAX_W+9)'(dec[AVG_W+7:Q_BITS]) + (R_MAX_W+9)'(inc);
        if (sum > (R_MAX_W+9)'(AVG_MAX)) begin
            leak = AVG_MAX;
        end else begin
            leak = sum[AVG_W-1:0];
        end
    endfunction

endpackage

[src/aebd_front.sv]
// Front end: takes samples, rectifies them and tags block start and end.
module aebd_front #(
    parameter int SAMPLE_BITS = 10,
    parameter int BLOCK_LEN   = 20,
    parameter int RW          = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [SAMPLE_BITS-1:0]    i_sample,
    input  logic [aebd_pkg::CFG_W-1:0] i_centre,
    input  logic                      i_full,
    output logic                      o_push,
    output logic [RW+1:0]             o_data
);
    import aebd_pkg::*;

    localparam int CNT_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [RW-1:0]    s_ext;
    logic [RW-1:0]    c_ext;
    logic [RW-1:0]    rect;
    logic             accept;
    t_tag             tag;

    assign s_ext  = RW'(i_sample);
    assign c_ext  = RW'(i_centre);
    assign rect   = (s_ext > c_ext) ? (s_ext - c_ext) : (c_ext - s_ext);
    assign o_ready = !i_full;
    assign accept = i_valid && !i_full;
    assign o_push = accept;

    assign tag.first = (r_cnt == '0);
    assign tag.last  = (r_cnt == CNT_W'(BLOCK_LEN - 1));
    assign o_data    = {tag, rect};

    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            n_cnt = tag.last ? '0 : r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

[src/aebd_queue.sv]
// Small flip-flop FIFO between the front end and the averaging back end.
`include "assert_macros.svh"
module aebd_queue #(
    parameter int W     = 12,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    import aebd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= bump(r_wr);
            end
            if (pop) begin
                r_rd <= bump(r_rd);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `AEBD_ASSERT(a_q_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `AEBD_ASSERT(a_q_grow, i_clk, i_rst_n, push && !pop |=> r_count == $past(r_count) + CW'(1))
    `AEBD_ASSERT(a_q_shrink, i_clk, i_rst_n, pop && !push |=> r_count == $past(r_count) - CW'(1))

endmodule

[src/aebd_back.sv]
// Back end: block leaky average, running average update, beat decision.
`include "assert_macros.svh"
module aebd_back #(
    parameter int RW = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  logic [RW+1:0]              i_q_data,
    output logic                       o_q_pop,
    input  logic [aebd_pkg::CFG_W-1:0] i_min,
    input  logic [aebd_pkg::CFG_W-1:0] i_ratio,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [aebd_pkg::LVL_W-1:0] o_volume,
    output logic                       o_beat,
    output logic [aebd_pkg::LVL_W-1:0] o_running_level
);
    import aebd_pkg::*;

    localparam int PROD_W = AVG_W + CFG_W;

    t_tag              tag;
    logic [RW-1:0]     rect;
    logic [AVG_W-1:0]  blk_base;
    logic [AVG_W-1:0]  n_blk;
    logic [AVG_W-1:0]  n_run;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] vol_scaled;
    logic              c_cond;
    logic              o_free;
    logic              c_move;
    logic              c_free;
    logic              b_move;
    logic              b_free;

    // stage A: per-sample accumulator
    logic [AVG_W-1:0] r_blk;
    // stage B: finished block volume
    logic             r_b_valid;
    logic [LVL_W-1:0] r_b_vol;
    // stage C: volume with updated running average
    logic             r_c_valid;
    logic [LVL_W-1:0] r_c_vol;
    logic [AVG_W-1:0] r_run;
    logic             r_armed;
    // output register
    logic             r_o_valid;
    logic [LVL_W-1:0] r_o_vol;
    logic             r_o_beat;
    logic [LVL_W-1:0] r_o_run;

    assign tag  = t_tag'(i_q_data[RW+1:RW]);
    assign rect = i_q_data[RW-1:0];

    assign o_free  = !r_o_valid || i_ready;
    assign c_move  = r_c_valid && o_free;
    assign c_free  = !r_c_valid || c_move;
    assign b_move  = r_b_valid && c_free;
    assign b_free  = !r_b_valid || b_move;
    assign o_q_pop = i_q_valid && (!tag.last || b_free);

    assign blk_base = tag.first ? '0 : r_blk;
    assign n_blk    = leak(blk_base, R_MAX_W'(rect));
    assign n_run    = leak(r_run, R_MAX_W'(r_b_vol));

    assign prod       = r_run * i_ratio;
    assign vol_scaled = PROD_W'({r_c_vol, {(2*Q_BITS){1'b0}}});
    assign c_cond     = (prod < vol_scaled) && (r_c_vol > i_min);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_blk <= n_blk;
        end
        if (o_q_pop && tag.last) begin
            r_b_vol <= n_blk[AVG_W-1:AVG_W-LVL_W];
        end
        if (b_move) begin
            r_c_vol <= r_b_vol;
        end
        if (c_move) begin
            r_o_vol  <= r_c_vol;
            r_o_beat <= c_cond && !r_armed;
            r_o_run  <= r_run[AVG_W-1:AVG_W-LVL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_run     <= '0;
            r_armed   <= 1'b0;
        end else begin
            if (o_q_pop && tag.last) begin
                r_b_valid <= 1'b1;
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end
            if (b_move) begin
                r_c_valid <= 1'b1;
                r_run     <= n_run;
            end else if (c_move) begin
                r_c_valid <= 1'b0;
            end
            if (c_move) begin
                r_o_valid <= 1'b1;
                r_armed   <= c_cond;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_o_valid;
    assign o_volume        = r_o_vol;
    assign o_beat          = r_o_beat;
    assign o_running_level = r_o_run;

    `AEBD_ASSERT(a_beat_above_min, i_clk, i_rst_n, r_o_valid && r_o_beat |-> r_o_vol > i_min)
    `AEBD_ASSERT(a_beat_disarms, i_clk, i_rst_n, c_move && c_cond |=> r_armed)
    `AEBD_ASSERT(a_mid_block_flows, i_clk, i_rst_n, i_q_valid && !tag.last |-> o_q_pop)

endmodule

[src/audio_envelope_beat_detector_top.sv]
// Top level of the audio envelope follower and energy beat detector.
//
//  channel   handshake                     payload
//  -------   ---------------------------   -----------------------------------
//  input     i_in_valid / o_in_ready       i_sample
//  output    o_out_valid / i_out_ready     o_volume, o_beat, o_running_level
//  config    i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// One sample is taken per cycle while the queue is not full; a 4-entry queue separates
// the sample front end from the averaging back end. After its last sample is accepted,
// a block's result passes the queue, block average, running average and ratio compare
// registers, then is offered. Reset is synchronous, active low, with no clearing pass.
// A stalled output holds one result, the pipeline holds two more, then the queue fills.
module audio_envelope_beat_detector_top #(
    parameter int BLOCK_LEN   = 20,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [SAMPLE_BITS-1:0]         i_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [aebd_pkg::LVL_W-1:0]     o_volume,
    output logic                           o_beat,
    output logic [aebd_pkg::LVL_W-1:0]     o_running_level,
    input  logic                           i_cfg_we,
    input  logic [aebd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [aebd_pkg::CFG_W-1:0]     i_cfg_data
);
    import aebd_pkg::*;

    localparam int RW    = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
    localparam int QW    = RW + 2;
    localparam int Q_DEP = 4;

    logic [CFG_W-1:0] r_centre;
    logic [CFG_W-1:0] r_min;
    logic [CFG_W-1:0] r_ratio;

    logic          q_full;
    logic          q_push;
    logic [QW-1:0] q_wdata;
    logic          q_pop;
    logic          q_valid;
    logic [QW-1:0] q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre <= CENTRE_RST;
            r_min    <= MIN_RST;
            r_ratio  <= RATIO_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CENTRE: r_centre <= i_cfg_data;
                CFG_MIN:    r_min    <= i_cfg_data;
                CFG_RATIO:  r_ratio  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    aebd_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .BLOCK_LEN   (BLOCK_LEN),
        .RW          (RW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_sample (i_sample),
        .i_centre (r_centre),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_data   (q_wdata)
    );

    aebd_queue #(
        .W     (QW),
        .DEPTH (Q_DEP)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    aebd_back #(
        .RW (RW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_data        (q_rdata),
        .o_q_pop         (q_pop),
        .i_min           (r_min),
        .i_ratio         (r_ratio),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_volume        (o_volume),
        .o_beat          (o_beat),
        .o_running_level (o_running_level)
    );

endmodule
